// ===== sv/gvc_pkg.sv =====
// shared widths, types and helpers for the greedy vertex colouring block
package gvc_pkg;

  localparam int unsigned VID_W   = 5;
  localparam int unsigned MASK_W  = 32;
  localparam int unsigned COLOR_W = 5;
  localparam int unsigned USED_W  = 1 << COLOR_W;

  typedef logic [VID_W-1:0]   vid_t;
  typedef logic [MASK_W-1:0]  mask_t;
  typedef logic [COLOR_W-1:0] color_t;
  typedef logic [USED_W-1:0]  used_t;

  // finished result handed from the sequencer to the output register
  typedef struct packed {
    logic   valid;
    vid_t   vertex_id;
    color_t color;
  } result_t;

  // lowest colour whose bit is clear in the used set
  function automatic color_t lowest_free(input used_t used);
    color_t c;
    c = '0;
    for (int i = USED_W - 1; i >= 0; i--) begin
      if (!used[i]) begin
        c = COLOR_W'(i);
      end
    end
    return c;
  endfunction

endpackage

// ===== sv/gvc_if.sv =====
// valid/ready channel interfaces for items and results
interface gvc_in_if;
  import gvc_pkg::*;
  logic  valid;
  logic  ready;
  vid_t  vertex_id;
  mask_t neighbor_mask;
  logic  restart;

  modport source (output valid, output vertex_id, output neighbor_mask, output restart,
                  input ready);
  modport sink   (input valid, input vertex_id, input neighbor_mask, input restart,
                  output ready);
endinterface

interface gvc_out_if;
  import gvc_pkg::*;
  logic   valid;
  logic   ready;
  vid_t   vertex_echo;
  color_t assigned_color;

  modport source (output valid, output vertex_echo, output assigned_color, input ready);
  modport sink   (input valid, input vertex_echo, input assigned_color, output ready);
endinterface

// ===== sv/gvc_ram.sv =====
// generic single write port, single registered read port ram
module gvc_ram #(
  parameter int unsigned WIDTH = 5,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

endmodule

// ===== sv/gvc_seq.sv =====
// sequencer: scans the colour table over the neighbours and picks the free colour
module gvc_seq #(
  parameter int unsigned VERTEX_COUNT = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // item transfer
  input  logic                            in_valid,
  output logic                            in_ready,
  input  gvc_pkg::vid_t                   in_vertex_id,
  input  gvc_pkg::mask_t                  in_neighbor_mask,
  input  logic                            in_restart,
  // colour table access
  output logic                            ram_re,
  output logic [$clog2(VERTEX_COUNT)-1:0] ram_raddr,
  input  gvc_pkg::color_t                 ram_rdata,
  output logic                            ram_we,
  output logic [$clog2(VERTEX_COUNT)-1:0] ram_waddr,
  output gvc_pkg::color_t                 ram_wdata,
  // result towards the output register
  input  logic                            out_busy,
  output gvc_pkg::result_t                result
);
  import gvc_pkg::*;

  localparam int unsigned IDX_W  = $clog2(VERTEX_COUNT);
  localparam int unsigned SCAN_N = (VERTEX_COUNT < MASK_W) ? VERTEX_COUNT : MASK_W;
  localparam int unsigned J_W    = $clog2(SCAN_N);
  localparam logic [J_W-1:0] J_LAST = J_W'(SCAN_N - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FIND
  } state_t;

  state_t                 state_r;
  logic [J_W-1:0]         j_r;
  logic                   rd_vld_r;
  logic [J_W-1:0]         rd_j_r;
  logic [VERTEX_COUNT-1:0] marks_r;
  used_t                  used_r;
  vid_t                   vid_r;
  mask_t                  mask_r;

  logic                   accept;
  logic                   hit;
  logic                   fire;
  logic                   store;
  color_t                 free_color;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // a returned entry counts when it is a coloured neighbour other than the vertex itself
  assign hit = rd_vld_r && mask_r[VID_W'(rd_j_r)] && marks_r[IDX_W'(rd_j_r)]
               && (VID_W'(rd_j_r) != vid_r);

  // result only when the output register can take it
  assign free_color = lowest_free(used_r);
  assign fire       = (state_r == ST_FIND) && !out_busy;
  assign store      = 32'(vid_r) < VERTEX_COUNT;

  // table read during the scan
  assign ram_re    = (state_r == ST_SCAN);
  assign ram_raddr = IDX_W'(j_r);

  // table write on completion
  assign ram_we    = fire && store;
  assign ram_waddr = IDX_W'(vid_r);
  assign ram_wdata = free_color;

  assign result.valid     = fire;
  assign result.vertex_id = vid_r;
  assign result.color     = free_color;

  // state, scan counter, marks and used-colour set
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      rd_vld_r <= 1'b0;
      marks_r  <= '0;
    end else begin
      rd_vld_r <= (state_r == ST_SCAN);
      rd_j_r   <= j_r;
      if (hit) begin
        used_r <= used_r | (USED_W'(1) << ram_rdata);
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            vid_r  <= in_vertex_id;
            mask_r <= in_neighbor_mask;
            used_r <= '0;
            j_r    <= '0;
            if (in_restart) begin
              marks_r <= '0;
            end
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          j_r <= j_r + J_W'(1);
          if (j_r == J_LAST) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state_r <= ST_FIND;
        end
        ST_FIND: begin
          if (fire) begin
            if (store) begin
              marks_r[IDX_W'(vid_r)] <= 1'b1;
            end
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/greedy_vertex_coloring_top.sv =====
// greedy vertex colouring: one item in, one colour out after a colour table scan
// an item passes through the scan, drain and find states; a new item is accepted only
//   once its result is in the output register, and find waits while that is full;
//   the scan reads the colour table memory one entry per cycle
// reset: synchronous active low; clears the coloured marks and the control state,
//   the colour table itself is not cleared and no clearing pass is needed
module greedy_vertex_coloring_top #(
  parameter int unsigned VERTEX_COUNT = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  gvc_in_if.sink           in_if,
  gvc_out_if.source        out_if
);
  import gvc_pkg::*;

  localparam int unsigned IDX_W = $clog2(VERTEX_COUNT);

  logic             ram_re;
  logic [IDX_W-1:0] ram_raddr;
  color_t           ram_rdata;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  color_t           ram_wdata;
  logic             out_busy;
  result_t          result;

  logic             out_valid_r;
  vid_t             out_vid_r;
  color_t           out_color_r;

  // colour table
  gvc_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (VERTEX_COUNT)
  ) u_color_table (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (ram_re),
    .raddr   (ram_raddr),
    .rdata_r (ram_rdata)
  );

  // sequencer
  gvc_seq #(
    .VERTEX_COUNT (VERTEX_COUNT)
  ) u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_if.valid),
    .in_ready         (in_if.ready),
    .in_vertex_id     (in_if.vertex_id),
    .in_neighbor_mask (in_if.neighbor_mask),
    .in_restart       (in_if.restart),
    .ram_re           (ram_re),
    .ram_raddr        (ram_raddr),
    .ram_rdata        (ram_rdata),
    .ram_we           (ram_we),
    .ram_waddr        (ram_waddr),
    .ram_wdata        (ram_wdata),
    .out_busy         (out_busy),
    .result           (result)
  );

  // output register, held until its transfer
  assign out_busy = out_valid_r && !out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (result.valid) begin
        out_valid_r <= 1'b1;
        out_vid_r   <= result.vertex_id;
        out_color_r <= result.color;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.vertex_echo    = out_vid_r;
  assign out_if.assigned_color = out_color_r;

endmodule
